>>> rtl/ubac_pkg.sv
`timescale 1ns / 1ps

package ubac_pkg;

  // Frame size limits and the derived position widths.
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Pixel and configuration port widths.
  localparam int PIX_W     = 32;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  typedef logic [PIX_W-1:0] pixel_t;

  // A pixel of this value never counts as a valid uniform colour.
  localparam pixel_t SENTINEL_COLOUR = 32'h00DE_AD00;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Size registers come out of reset at 100, kept here as size minus one.
  localparam logic [CFG_W-1:0] SIZE_RESET      = 8'd100;
  localparam logic [COL_W-1:0] WIDTH_M1_RESET  = COL_W'(SIZE_RESET - 8'd1);
  localparam logic [ROW_W-1:0] HEIGHT_M1_RESET = ROW_W'(SIZE_RESET - 8'd1);

  // Clamp a written size into 1..max_v.
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] max_v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = 8'd1;
    end else if (v > max_v) begin
      r = max_v;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/ubac_ram.sv
`timescale 1ns / 1ps

module ubac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/uniform_border_autocrop.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_pixel_value (32 bit, raster order)
// out      output     out_valid / out_ready top, bottom, left, right edges, whole flag
// cfg      input      cfg_we                cfg_index, cfg_wdata (write only)
//
// Pixels are taken one per cycle while a frame is streaming in.
// After the last pixel of a frame the column memory is scanned from the left and then
// from the right, one column read per cycle, through the single read port of the column
// colour memory.
// rst_n is synchronous; afterwards both sizes are 100 and no frame is in progress.
// The result sits in an output register, so a stalled out_ready only blocks the next
// frame end, not the pixels before it.

module uniform_border_autocrop (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ubac_pkg::pixel_t               in_pixel_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ubac_pkg::ROW_W-1:0]     out_top_edge,
  output logic [ubac_pkg::ROW_W:0]       out_bottom_edge,
  output logic [ubac_pkg::COL_W-1:0]     out_left_edge,
  output logic [ubac_pkg::COL_W:0]       out_right_edge,
  output logic                           out_whole_uniform,
  input  logic                           cfg_we,
  input  logic [ubac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ubac_pkg::CFG_W-1:0]     cfg_wdata
);

  import ubac_pkg::*;

  typedef enum logic [1:0] {ST_RUN, ST_SCAN, ST_DONE} state_t;

  state_t           state_r, state_nxt;
  logic [COL_W-1:0] wm1_r, wm1_nxt;
  logic [ROW_W-1:0] hm1_r, hm1_nxt;

  // Frame position and row tracking.
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  pixel_t           row_first_r, row_first_nxt;
  logic             row_uni_r, row_uni_nxt;

  // Top band and trailing (bottom) run.
  pixel_t           top_col_r, top_col_nxt;
  logic [ROW_W-1:0] top_idx_r, top_idx_nxt;
  logic             top_done_r, top_done_nxt;
  pixel_t           tr_col_r, tr_col_nxt;
  logic             tr_valid_r, tr_valid_nxt;
  logic [ROW_W-1:0] tr_start_r, tr_start_nxt;

  // Column uniform flags and the compare stage behind the memory read.
  logic [MAX_WIDTH-1:0] col_uni_r, col_uni_nxt;
  logic                 s2_chk_r, s2_chk_nxt;
  logic [COL_W-1:0]     s2_col_r, s2_col_nxt;
  pixel_t               s2_pix_r, s2_pix_nxt;

  // Frame results: row results gathered before the column scan, column edges found by it.
  logic [ROW_W-1:0] res_top_r, res_top_nxt;
  logic [ROW_W:0]   res_bot_r, res_bot_nxt;
  logic             res_whole_r, res_whole_nxt;
  logic [COL_W-1:0] res_left_r, res_left_nxt;
  logic [COL_W:0]   res_right_r, res_right_nxt;

  // Column scan sequencer.
  logic             right_ph_r, right_ph_nxt;
  logic [COL_W-1:0] iss_i_r, iss_i_nxt;
  logic             iss_done_r, iss_done_nxt;
  logic             ev_valid_r, ev_valid_nxt;
  logic             ev_first_r, ev_first_nxt;
  logic [COL_W-1:0] ev_x_r, ev_x_nxt;
  pixel_t           edge_r, edge_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0] out_top_r, out_top_nxt;
  logic [ROW_W:0]   out_bot_r, out_bot_nxt;
  logic [COL_W-1:0] out_left_r, out_left_nxt;
  logic [COL_W:0]   out_right_r, out_right_nxt;
  logic             out_whole_r, out_whole_nxt;

  // Memory port.
  logic             mem_we, mem_re;
  logic [COL_W-1:0] mem_raddr;
  pixel_t           mem_rdata;

  // Combinational helpers.
  logic             accept;
  logic             issue;
  logic [COL_W-1:0] scan_addr;
  pixel_t           first_pix;
  logic             row_uni_now;
  logic             rv;
  logic             cvalid;
  logic             stop;
  logic [ROW_W:0]   h_full;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_RUN);
  assign issue     = (state_r == ST_SCAN) && !iss_done_r;
  assign scan_addr = right_ph_r ? (wm1_r - iss_i_r) : iss_i_r;
  assign h_full    = {1'b0, hm1_r} + 1'b1;

  assign mem_we    = accept && (row_r == '0);
  assign mem_re    = (accept && (row_r != '0)) || issue;
  assign mem_raddr = (state_r == ST_SCAN) ? scan_addr : col_r;

  ubac_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (col_r),
    .wdata (in_pixel_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Row uniformity including the pixel now being taken.
  assign first_pix   = (col_r == '0) ? in_pixel_value : row_first_r;
  assign row_uni_now = (col_r == '0) ? 1'b1 : (row_uni_r && (in_pixel_value == row_first_r));
  assign rv          = row_uni_now && (first_pix != SENTINEL_COLOUR);

  // Scan evaluation of the column whose colour has just come back.
  assign cvalid = col_uni_r[ev_x_r] && (mem_rdata != SENTINEL_COLOUR);
  assign stop   = ev_valid_r &&
                  (!cvalid || (!ev_first_r && (mem_rdata != edge_r)) ||
                   (right_ph_r ? (ev_x_r == '0) : (ev_x_r == wm1_r)));

  always_comb begin
    state_nxt     = state_r;
    wm1_nxt       = wm1_r;
    hm1_nxt       = hm1_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    row_first_nxt = row_first_r;
    row_uni_nxt   = row_uni_r;
    top_col_nxt   = top_col_r;
    top_idx_nxt   = top_idx_r;
    top_done_nxt  = top_done_r;
    tr_col_nxt    = tr_col_r;
    tr_valid_nxt  = tr_valid_r;
    tr_start_nxt  = tr_start_r;
    col_uni_nxt   = col_uni_r;
    res_top_nxt   = res_top_r;
    res_bot_nxt   = res_bot_r;
    res_whole_nxt = res_whole_r;
    res_left_nxt  = res_left_r;
    res_right_nxt = res_right_r;
    right_ph_nxt  = right_ph_r;
    iss_i_nxt     = iss_i_r;
    iss_done_nxt  = iss_done_r;
    edge_nxt      = edge_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_top_nxt   = out_top_r;
    out_bot_nxt   = out_bot_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_whole_nxt = out_whole_r;

    // Compare stage: clear the column flag when a later row differs.
    s2_chk_nxt = accept && (row_r != '0);
    s2_col_nxt = col_r;
    s2_pix_nxt = in_pixel_value;
    if (s2_chk_r && (s2_pix_r != mem_rdata)) begin
      col_uni_nxt[s2_col_r] = 1'b0;
    end

    // Scan issue side.
    ev_valid_nxt = issue;
    ev_first_nxt = (iss_i_r == '0);
    ev_x_nxt     = scan_addr;
    if (issue) begin
      iss_i_nxt    = iss_i_r + 1'b1;
      iss_done_nxt = (iss_i_r == wm1_r);
    end

    // Pixel transfer: row, column and band tracking.
    if (accept) begin
      row_first_nxt = first_pix;
      row_uni_nxt   = row_uni_now;
      if (row_r == '0) begin
        col_uni_nxt[col_r] = 1'b1;
      end
      if (col_r != wm1_r) begin
        col_nxt = col_r + 1'b1;
      end else begin
        col_nxt = '0;
        if (row_r == '0) begin
          top_col_nxt = first_pix;
          if (!rv) begin
            top_done_nxt = 1'b1;
            top_idx_nxt  = '0;
          end
        end else if (!top_done_r && (!rv || (first_pix != top_col_r))) begin
          top_done_nxt = 1'b1;
          top_idx_nxt  = row_r;
        end
        if (!rv) begin
          tr_valid_nxt = 1'b0;
        end else if (!(tr_valid_r && (first_pix == tr_col_r))) begin
          tr_col_nxt   = first_pix;
          tr_valid_nxt = 1'b1;
          tr_start_nxt = row_r;
        end
        if (row_r != hm1_r) begin
          row_nxt = row_r + 1'b1;
        end else begin
          // Frame end: latch the row results and start the column scan.
          res_top_nxt   = top_done_nxt ? top_idx_nxt : hm1_r;
          if (!tr_valid_nxt) begin
            res_bot_nxt = h_full;
          end else if (tr_start_nxt != '0) begin
            res_bot_nxt = {1'b0, tr_start_nxt};
          end else begin
            res_bot_nxt = (ROW_W+1)'(1);
          end
          res_whole_nxt = tr_valid_nxt && (tr_start_nxt == '0);
          row_nxt       = '0;
          row_first_nxt = '0;
          row_uni_nxt   = 1'b1;
          top_col_nxt   = '0;
          top_idx_nxt   = '0;
          top_done_nxt  = 1'b0;
          tr_col_nxt    = '0;
          tr_valid_nxt  = 1'b0;
          tr_start_nxt  = '0;
          right_ph_nxt  = 1'b0;
          iss_i_nxt     = '0;
          iss_done_nxt  = 1'b0;
          state_nxt     = ST_SCAN;
        end
      end
    end

    // Scan evaluation: remember the outer colour and stop at the first mismatch.
    if (ev_valid_r && ev_first_r) begin
      edge_nxt = mem_rdata;
    end
    if (stop) begin
      ev_valid_nxt = 1'b0;
      iss_i_nxt    = '0;
      iss_done_nxt = 1'b0;
      if (!right_ph_r) begin
        res_left_nxt = ev_x_r;
        right_ph_nxt = 1'b1;
      end else begin
        res_right_nxt = {1'b0, ev_x_r} + 1'b1;
        iss_done_nxt  = 1'b1;
        state_nxt     = ST_DONE;
      end
    end

    // Hand the result to the output register once it is free.
    if ((state_r == ST_DONE) && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      out_top_nxt   = res_top_r;
      out_bot_nxt   = res_bot_r;
      out_left_nxt  = res_left_r;
      out_right_nxt = res_right_r;
      out_whole_nxt = res_whole_r;
      state_nxt     = ST_RUN;
    end

    // Configuration write restarts the frame.
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH: begin
          wm1_nxt = COL_W'(clamp_size(cfg_wdata, CFG_W'(MAX_WIDTH)) - 8'd1);
        end
        CFG_FRAME_HEIGHT: begin
          hm1_nxt = ROW_W'(clamp_size(cfg_wdata, CFG_W'(MAX_HEIGHT)) - 8'd1);
        end
        default: begin
          wm1_nxt = wm1_r;
        end
      endcase
      col_nxt       = '0;
      row_nxt       = '0;
      row_first_nxt = '0;
      row_uni_nxt   = 1'b1;
      top_col_nxt   = '0;
      top_idx_nxt   = '0;
      top_done_nxt  = 1'b0;
      tr_col_nxt    = '0;
      tr_valid_nxt  = 1'b0;
      tr_start_nxt  = '0;
    end
  end

  // State, control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      wm1_r       <= WIDTH_M1_RESET;
      hm1_r       <= HEIGHT_M1_RESET;
      col_r       <= '0;
      row_r       <= '0;
      row_first_r <= '0;
      row_uni_r   <= 1'b1;
      top_col_r   <= '0;
      top_idx_r   <= '0;
      top_done_r  <= 1'b0;
      tr_col_r    <= '0;
      tr_valid_r  <= 1'b0;
      tr_start_r  <= '0;
      col_uni_r   <= '0;
      s2_chk_r    <= 1'b0;
      right_ph_r  <= 1'b0;
      iss_i_r     <= '0;
      iss_done_r  <= 1'b0;
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wm1_r       <= wm1_nxt;
      hm1_r       <= hm1_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      row_first_r <= row_first_nxt;
      row_uni_r   <= row_uni_nxt;
      top_col_r   <= top_col_nxt;
      top_idx_r   <= top_idx_nxt;
      top_done_r  <= top_done_nxt;
      tr_col_r    <= tr_col_nxt;
      tr_valid_r  <= tr_valid_nxt;
      tr_start_r  <= tr_start_nxt;
      col_uni_r   <= col_uni_nxt;
      s2_chk_r    <= s2_chk_nxt;
      right_ph_r  <= right_ph_nxt;
      iss_i_r     <= iss_i_nxt;
      iss_done_r  <= iss_done_nxt;
      ev_valid_r  <= ev_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s2_col_r    <= s2_col_nxt;
    s2_pix_r    <= s2_pix_nxt;
    ev_first_r  <= ev_first_nxt;
    ev_x_r      <= ev_x_nxt;
    edge_r      <= edge_nxt;
    res_top_r   <= res_top_nxt;
    res_bot_r   <= res_bot_nxt;
    res_whole_r <= res_whole_nxt;
    res_left_r  <= res_left_nxt;
    res_right_r <= res_right_nxt;
    out_top_r   <= out_top_nxt;
    out_bot_r   <= out_bot_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_whole_r <= out_whole_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_top_edge      = out_top_r;
  assign out_bottom_edge   = out_bot_r;
  assign out_left_edge     = out_left_r;
  assign out_right_edge    = out_right_r;
  assign out_whole_uniform = out_whole_r;

  // Column memory is never written while the scan owns the read port.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> !mem_we)
    else $error("column memory written outside the pixel phase");

  // A new result only appears right after the scan has finished.
  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == ST_DONE))
    else $error("result presented without a completed scan");

  // Scanned columns stay inside the frame width.
  a_scan_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid_r |-> (ev_x_r <= wm1_r))
    else $error("scan evaluated a column beyond the frame width");

  // Leaving the done state always restarts at the first pixel of a frame.
  a_restart_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && $past(state_r == ST_DONE)) |-> ((col_r == '0) && (row_r == '0)))
    else $error("frame position not cleared after a result");

endmodule

>>> test/uniform_border_autocrop_test.sv
`timescale 1ns / 1ps

module uniform_border_autocrop_test;
  import ubac_pkg::*;

  // Tail allowance after a frame end: the column scan reads each column at most twice.
  localparam int TAIL_CYCLES   = 2 * MAX_WIDTH + 16;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int RANDOM_PIXELS = 600;
  localparam int RANDOM_FRAMES = 40;

  typedef enum int {FRAME_FLAT, FRAME_BOX, FRAME_STRIPES, FRAME_NOISE} frame_style_t;

  // One crop result, as the block reports it.
  typedef struct {
    logic [ROW_W-1:0] top;
    logic [ROW_W:0]   bottom;
    logic [COL_W-1:0] left;
    logic [COL_W:0]   right;
    logic             whole;
  } crop_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  pixel_t               in_pixel_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ROW_W-1:0]     out_top_edge;
  logic [ROW_W:0]       out_bottom_edge;
  logic [COL_W-1:0]     out_left_edge;
  logic [COL_W:0]       out_right_edge;
  logic                 out_whole_uniform;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  uniform_border_autocrop i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_value    (in_pixel_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_top_edge      (out_top_edge),
    .out_bottom_edge   (out_bottom_edge),
    .out_left_edge     (out_left_edge),
    .out_right_edge    (out_right_edge),
    .out_whole_uniform (out_whole_uniform),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Stimulus and scoreboard bookkeeping.
  pixel_t      pixel_queue [$];
  crop_t       pending_crops [$];
  crop_t       want_crop;
  pixel_t      canvas [MAX_HEIGHT][MAX_WIDTH];
  pixel_t      palette [3];
  int unsigned pixels_pushed = 0;
  int unsigned pixels_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned in_gap_pct = 25;
  int unsigned out_stall_pct = 25;
  int unsigned hold_at_result = 32'h7FFF_FFFF;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  // Mirror of the block: size registers and per-frame tracking state.
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  pixel_t           col_colour [MAX_WIDTH];
  logic             col_uni [MAX_WIDTH];
  pixel_t           row_first;
  logic             row_uni;
  int unsigned      row_pos;
  int unsigned      col_pos;
  pixel_t           top_colour;
  int unsigned      top_idx;
  logic             top_done;
  pixel_t           run_colour;
  logic             run_valid;
  int unsigned      run_start;

  function automatic int unsigned size_in_use(input logic [CFG_W-1:0] v,
                                              input int unsigned limit);
    if (v == '0) begin
      return 1;
    end else if (v > limit) begin
      return limit;
    end
    return v;
  endfunction

  function automatic void clear_frame_state();
    row_first  = '0;
    row_uni    = 1'b1;
    row_pos    = 0;
    col_pos    = 0;
    top_colour = '0;
    top_idx    = 0;
    top_done   = 1'b0;
    run_colour = '0;
    run_valid  = 1'b0;
    run_start  = 0;
  endfunction

  // Walk the columns inward from one side; stop at the first column that breaks the band.
  function automatic int unsigned scan_cols(input int unsigned w, input logic from_left);
    int unsigned i;
    int unsigned x;
    pixel_t      edge_colour;
    edge_colour = '0;
    for (i = 0; i < w; i++) begin
      x = from_left ? i : w - 1 - i;
      if (!col_uni[x] || col_colour[x] == SENTINEL_COLOUR) begin
        return x;
      end
      if (i == 0) begin
        edge_colour = col_colour[x];
      end else if (col_colour[x] != edge_colour) begin
        return x;
      end
    end
    return from_left ? w - 1 : 0;
  endfunction

  // Fold one accepted pixel into the mirror; queue the crop when the frame completes.
  function automatic void track_pixel(input pixel_t p);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    logic        row_ok;
    crop_t       r;
    w   = size_in_use(width_reg, MAX_WIDTH);
    h   = size_in_use(height_reg, MAX_HEIGHT);
    col = col_pos;
    row = row_pos;
    if (col >= w || row >= h) begin
      clear_frame_state();
      col = 0;
      row = 0;
    end

    if (col == 0) begin
      row_first = p;
      row_uni   = 1'b1;
    end else if (p != row_first) begin
      row_uni = 1'b0;
    end

    if (row == 0) begin
      col_colour[col] = p;
      col_uni[col]    = 1'b1;
    end else if (p != col_colour[col]) begin
      col_uni[col] = 1'b0;
    end

    if (col + 1 < w) begin
      col_pos = col + 1;
      return;
    end
    col_pos = 0;

    // End of a row: update the top band and the run of matching rows at the bottom.
    row_ok = row_uni && row_first != SENTINEL_COLOUR;
    if (row == 0) begin
      top_colour = row_first;
      if (!row_ok) begin
        top_done = 1'b1;
        top_idx  = 0;
      end
    end else if (!top_done && (!row_ok || row_first != top_colour)) begin
      top_done = 1'b1;
      top_idx  = row;
    end

    if (!row_ok) begin
      run_valid = 1'b0;
    end else if (!(run_valid && row_first == run_colour)) begin
      run_colour = row_first;
      run_valid  = 1'b1;
      run_start  = row;
    end

    if (row + 1 < h) begin
      row_pos = row + 1;
      return;
    end

    r.top    = ROW_W'(top_done ? top_idx : h - 1);
    r.bottom = (ROW_W + 1)'(!run_valid ? h : (run_start > 0 ? run_start : 1));
    r.left   = COL_W'(scan_cols(w, 1'b1));
    r.right  = (COL_W + 1)'(scan_cols(w, 1'b0) + 1);
    r.whole  = run_valid && run_start == 0;
    pending_crops.push_back(r);
    clear_frame_state();
  endfunction

  function automatic void report_field(input string name, input int unsigned want,
                                       input int unsigned got);
    $error("%s: expected %0d, got %0d", name, want, got);
    fail_count++;
  endfunction

  // Colours come mostly from a small pool so that equal rows and columns happen often.
  function automatic pixel_t pick_colour();
    case ($urandom_range(11))
      0: return SENTINEL_COLOUR;
      1: return '0;
      2: return '1;
      3, 4, 5, 6, 7, 8: return palette[$urandom_range(2)];
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_size();
    case ($urandom_range(19))
      0: return '0;
      1: return CFG_W'($urandom_range(255, MAX_WIDTH + 1));
      2, 3: return CFG_W'($urandom_range(MAX_WIDTH, 11));
      default: return CFG_W'($urandom_range(10, 1));
    endcase
  endfunction

  // A rectangle anywhere in the frame, either one solid colour or noise.
  function automatic void paint_box(input int unsigned w, input int unsigned h);
    int unsigned x0, x1, y0, y1, x, y;
    logic        solid;
    pixel_t      fill;
    x0    = $urandom_range(w - 1);
    x1    = $urandom_range(w - 1, x0);
    y0    = $urandom_range(h - 1);
    y1    = $urandom_range(h - 1, y0);
    solid = $urandom_range(1);
    fill  = pick_colour();
    for (y = y0; y <= y1; y++) begin
      for (x = x0; x <= x1; x++) begin
        canvas[y][x] = solid ? fill : pick_colour();
      end
    end
  endfunction

  function automatic void paint_frame(input int unsigned w, input int unsigned h,
                                      input frame_style_t style, input pixel_t bg);
    int unsigned x, y, band;
    pixel_t      c;
    for (y = 0; y < h; y++) begin
      for (x = 0; x < w; x++) begin
        canvas[y][x] = bg;
      end
    end
    case (style)
      FRAME_FLAT: begin
      end
      FRAME_BOX: begin
        paint_box(w, h);
      end
      FRAME_STRIPES: begin
        // Bands of their own colour on each side, then maybe a box and a stray pixel.
        band = $urandom_range(h / 2);
        c    = pick_colour();
        for (y = 0; y < band; y++) begin
          for (x = 0; x < w; x++) canvas[y][x] = c;
        end
        band = $urandom_range(h / 2);
        c    = pick_colour();
        for (y = h - band; y < h; y++) begin
          for (x = 0; x < w; x++) canvas[y][x] = c;
        end
        band = $urandom_range(w / 2);
        c    = pick_colour();
        for (x = 0; x < band; x++) begin
          for (y = 0; y < h; y++) canvas[y][x] = c;
        end
        band = $urandom_range(w / 2);
        c    = pick_colour();
        for (x = w - band; x < w; x++) begin
          for (y = 0; y < h; y++) canvas[y][x] = c;
        end
        if ($urandom_range(1)) begin
          paint_box(w, h);
        end
        if ($urandom_range(3) == 0) begin
          canvas[$urandom_range(h - 1)][$urandom_range(w - 1)] = pick_colour();
        end
      end
      default: begin
        for (y = 0; y < h; y++) begin
          for (x = 0; x < w; x++) canvas[y][x] = pick_colour();
        end
      end
    endcase
  endfunction

  // Queue the first count pixels of the canvas in raster order.
  task automatic push_pixels(input int unsigned w, input int unsigned count);
    int unsigned n;
    @(negedge clk);
    for (n = 0; n < count; n++) begin
      pixel_queue.push_back(canvas[n / w][n % w]);
    end
    pixels_pushed += count;
  endtask

  task automatic queue_frame(input int unsigned w, input int unsigned h,
                             input frame_style_t style, input pixel_t bg);
    paint_frame(w, h, style, bg);
    push_pixels(w, w * h);
  endtask

  // Wait until every pixel is taken and every crop is back, then let the column scan finish.
  task automatic drain();
    while (pixels_accepted != pixels_pushed || pending_crops.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) begin
      width_reg = val;
    end else begin
      height_reg = val;
    end
    clear_frame_state();
  endtask

  task automatic set_frame_size(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
    write_reg(CFG_FRAME_WIDTH, wv);
    write_reg(CFG_FRAME_HEIGHT, hv);
  endtask

  // Input side: once the previous transfer has completed, offer the next queued pixel or idle at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_pixel(in_pixel_value);
        pixels_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= in_gap_pct) begin
          in_valid       <= 1'b1;
          in_pixel_value <= pixel_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: compare each transfer with the oldest pending crop, stall at random,
  // and once hold off for a long stretch so the block backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_crops.size() == 0) begin
          $error("result transfer with no frame pending");
          fail_count++;
        end else begin
          want_crop = pending_crops.pop_front();
          if (out_top_edge !== want_crop.top) begin
            report_field("top_edge", want_crop.top, out_top_edge);
          end
          if (out_bottom_edge !== want_crop.bottom) begin
            report_field("bottom_edge", want_crop.bottom, out_bottom_edge);
          end
          if (out_left_edge !== want_crop.left) begin
            report_field("left_edge", want_crop.left, out_left_edge);
          end
          if (out_right_edge !== want_crop.right) begin
            report_field("right_edge", want_crop.right, out_right_edge);
          end
          if (out_whole_uniform !== want_crop.whole) begin
            report_field("whole_uniform", want_crop.whole, out_whole_uniform);
          end
        end
        results_seen++;
      end
      if (!hold_done && results_seen >= hold_at_result) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("uniform_border_autocrop test failed");
      $finish;
    end
  end

  initial begin
    int unsigned      w, h, i, frames, frames_done, start_pixels, phase, roll;
    logic [CFG_W-1:0] wv, hv;
    frame_style_t     style;

    for (i = 0; i < 3; i++) begin
      palette[i] = $urandom;
    end
    width_reg  = SIZE_RESET;
    height_reg = SIZE_RESET;
    for (i = 0; i < MAX_WIDTH; i++) begin
      col_colour[i] = '0;
      col_uni[i]    = 1'b0;
    end
    clear_frame_state();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Sizes out of reset: one 100 x 100 frame, a box on a flat background.
    queue_frame(100, 100, FRAME_BOX, pick_colour());
    drain();

    // Sizes of zero clamp to one pixel; pixel extremes and the sentinel colour.
    set_frame_size('0, '0);
    queue_frame(1, 1, FRAME_FLAT, '0);
    queue_frame(1, 1, FRAME_FLAT, '1);
    queue_frame(1, 1, FRAME_FLAT, SENTINEL_COLOUR);
    drain();

    // One row at full width, flat and then with the sentinel in the last column.
    set_frame_size(8'd128, 8'd1);
    queue_frame(MAX_WIDTH, 1, FRAME_FLAT, 32'h8000_0001);
    paint_frame(MAX_WIDTH, 1, FRAME_FLAT, 32'h7FFF_FFFE);
    canvas[0][MAX_WIDTH-1] = SENTINEL_COLOUR;
    push_pixels(MAX_WIDTH, MAX_WIDTH);
    drain();

    // One column at full height; 255 clamps down to the maximum.
    set_frame_size(8'd1, 8'd255);
    queue_frame(1, MAX_HEIGHT, FRAME_FLAT, '1);
    queue_frame(1, MAX_HEIGHT, FRAME_FLAT, SENTINEL_COLOUR);
    queue_frame(1, MAX_HEIGHT, FRAME_STRIPES, '0);
    drain();

    // A width just past the maximum, two rows.
    set_frame_size(8'd129, 8'd2);
    queue_frame(MAX_WIDTH, 2, FRAME_STRIPES, pick_colour());
    queue_frame(MAX_WIDTH, 2, FRAME_NOISE, pick_colour());
    drain();

    // Small frames, then one cut short so the next register write abandons it.
    set_frame_size(8'd3, 8'd3);
    queue_frame(3, 3, FRAME_FLAT, palette[0]);
    queue_frame(3, 3, FRAME_STRIPES, palette[1]);
    queue_frame(3, 3, FRAME_BOX, palette[2]);
    paint_frame(3, 3, FRAME_NOISE, '0);
    push_pixels(3, 5);
    drain();
    set_frame_size(8'd3, 8'd3);
    queue_frame(3, 3, FRAME_BOX, pick_colour());
    drain();

    // Random phases: new sizes, a few frames each, sometimes a trailing partial frame.
    phase        = 0;
    frames_done  = 0;
    start_pixels = pixels_pushed;
    while (pixels_pushed - start_pixels < RANDOM_PIXELS || frames_done < RANDOM_FRAMES) begin
      wv = rand_size();
      hv = rand_size();
      if (size_in_use(wv, MAX_WIDTH) * size_in_use(hv, MAX_HEIGHT) > 400) begin
        hv = CFG_W'($urandom_range(3, 1));
      end
      frames        = $urandom_range(5, 1);
      in_gap_pct    = 25;
      out_stall_pct = 25;
      if (phase == 2) begin
        // A stretch with no idling on either side.
        in_gap_pct    = 0;
        out_stall_pct = 0;
        frames        = 8;
      end
      if (phase == 4) begin
        // Tiny frames while the result side holds off, so the input backs up.
        wv             = 8'd2;
        hv             = 8'd2;
        frames         = 16;
        hold_at_result = results_seen + 1;
      end
      set_frame_size(wv, hv);
      w = size_in_use(wv, MAX_WIDTH);
      h = size_in_use(hv, MAX_HEIGHT);
      repeat (frames) begin
        roll  = $urandom_range(9);
        style = roll < 2 ? FRAME_FLAT : roll < 5 ? FRAME_BOX :
                roll < 9 ? FRAME_STRIPES : FRAME_NOISE;
        queue_frame(w, h, style, pick_colour());
      end
      frames_done += frames;
      if (w * h > 1 && $urandom_range(9) < 3) begin
        paint_frame(w, h, FRAME_NOISE, pick_colour());
        push_pixels(w, $urandom_range(w * h - 1, 1));
      end
      drain();
      phase++;
    end

    if (fail_count == 0) begin
      $display("uniform_border_autocrop test passed");
    end else begin
      $display("uniform_border_autocrop test failed");
    end
    $finish;
  end

endmodule
